// ===== src/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

    // default number of stored records
    localparam int unsigned QueueDepthDefault = 32;

    // command codes carried on the input tuser
    localparam logic [2:0] KIND_INSERT     = 3'd0;
    localparam logic [2:0] KIND_POP        = 3'd1;
    localparam logic [2:0] KIND_LIST_ALL   = 3'd2;
    localparam logic [2:0] KIND_LIST_SCORE = 3'd3;
    localparam logic [2:0] KIND_LIST_LTR   = 3'd4;
    localparam logic [2:0] KIND_CLEAR      = 3'd5;

    // result status codes carried on the output tuser
    localparam logic [1:0] STAT_DONE   = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_RECORD = 2'd2;
    localparam logic [1:0] STAT_NONE   = 2'd3;

    localparam int unsigned RecWidth   = 42;
    localparam int unsigned TdataWidth = 48;

    // one stored record, tag in the lowest bits
    typedef struct packed {
        logic [7:0]  prio;
        logic [9:0]  score;
        logic [7:0]  letter;
        logic [15:0] tag;
    } rec_t;

    // sequencer states, one-hot
    typedef enum logic [9:0] {
        ST_IDLE     = 10'b0000000001,
        ST_INS_RD   = 10'b0000000010,
        ST_INS_CMP  = 10'b0000000100,
        ST_INS_PUT  = 10'b0000001000,
        ST_POP_RD   = 10'b0000010000,
        ST_POP_HEAD = 10'b0000100000,
        ST_POP_SH   = 10'b0001000000,
        ST_LST_RD   = 10'b0010000000,
        ST_LST      = 10'b0100000000,
        ST_RESP     = 10'b1000000000
    } state_t;

endpackage

`default_nettype wire

// ===== src/stable_priority_record_queue_top.sv =====
// stable priority record queue
// input channel s_*: one command per request, tuser = kind, tdata = record
//   (tag, letter, score, priority); list kinds use score or letter as filter
// output channel m_*: result requests, tuser = status, tdata = record,
//   tlast marks the final result of a command
// records are held in one memory with a write port and a read port, and kept
// in descending priority order, equal priorities in arrival order
// steps per command:
//   insert: shift lower-priority records up one at a time, then place the new one
//   pop:    head read, then one record moved per cycle
//   list:   one stored record examined per cycle unless an output stall holds it
//   clear and others: answer directly
// each step does at most one memory read and one write, so the memory sets
// the pace; s_tready is high only while the sequencer is idle
// a finished result waits in the output register while the next command
// is accepted; a stalled receiver holds the sequencer until the slot frees
// after reset (aresetn low, synchronous) the queue is empty and no result
// is pending; memory contents need no clearing
`default_nettype none

module stable_priority_record_queue_top #(
    parameter int unsigned QUEUE_DEPTH = spq_pkg::QueueDepthDefault
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // tag [15:0], letter [23:16], score [33:24], priority [41:34], zero fill
    input  wire logic [spq_pkg::TdataWidth-1:0]     s_tdata,
    // kind [2:0]
    input  wire logic [2:0]                         s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // tag [15:0], letter [23:16], score [33:24], priority [41:34], zero fill
    output logic [spq_pkg::TdataWidth-1:0]          m_tdata,
    // status [1:0]
    output logic [1:0]                              m_tuser,
    output logic                                    m_tlast
);
    import spq_pkg::*;

    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] OneC   = CW'(1);

    state_t        state_reg, state_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [2:0]    kind_reg, kind_next;
    rec_t          new_reg, new_next;
    rec_t          rec_reg, rec_next;
    logic          pend_reg, pend_next;
    logic [1:0]    resp_reg, resp_next;

    logic          m_tvalid_reg;
    logic [1:0]    m_status_reg;
    rec_t          m_rec_reg;
    logic          m_last_reg;

    rec_t          entries_reg [QUEUE_DEPTH];
    rec_t          rd_data_reg;

    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    rec_t          wr_data;

    logic          out_load;
    logic [1:0]    out_status;
    rec_t          out_rec;
    logic          out_last;

    logic          slot_free;
    logic          hit;
    logic          go;
    logic [CW-1:0] idx_m1, idx_m2, idx_p1;

    assign slot_free = !m_tvalid_reg || m_tready;
    assign idx_m1    = idx_reg - OneC;
    assign idx_m2    = idx_reg - CW'(2);
    assign idx_p1    = idx_reg + OneC;

    // filter match for list commands
    always_comb begin
        case (kind_reg)
            KIND_LIST_SCORE: hit = (rd_data_reg.score >= new_reg.score);
            KIND_LIST_LTR:   hit = (rd_data_reg.letter <= new_reg.letter);
            default:         hit = 1'b1;
        endcase
    end

    // list step may advance unless a second match needs the busy output slot
    assign go = !(hit && pend_reg) || slot_free;

    // sequencer
    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        kind_next  = kind_reg;
        new_next   = new_reg;
        rec_next   = rec_reg;
        pend_next  = pend_reg;
        resp_next  = resp_reg;
        rd_addr    = '0;
        wr_en      = 1'b0;
        wr_addr    = idx_reg[AW-1:0];
        wr_data    = new_reg;
        out_load   = 1'b0;
        out_status = STAT_DONE;
        out_rec    = rec_reg;
        out_last   = 1'b1;
        s_tready   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    kind_next  = s_tuser;
                    new_next   = rec_t'(s_tdata[RecWidth-1:0]);
                    idx_next   = fill_reg;
                    pend_next  = 1'b0;
                    resp_next  = STAT_DONE;
                    state_next = ST_RESP;
                    unique case (s_tuser) inside
                        KIND_INSERT: begin
                            if (fill_reg == DepthC) begin
                                resp_next = STAT_FULL;
                            end else if (fill_reg == '0) begin
                                state_next = ST_INS_PUT;
                            end else begin
                                state_next = ST_INS_RD;
                            end
                        end
                        KIND_POP: begin
                            if (fill_reg == '0) begin
                                resp_next = STAT_NONE;
                            end else begin
                                state_next = ST_POP_RD;
                            end
                        end
                        KIND_LIST_ALL, KIND_LIST_SCORE, KIND_LIST_LTR: begin
                            idx_next   = '0;
                            state_next = ST_LST_RD;
                        end
                        KIND_CLEAR: begin
                            fill_next = '0;
                        end
                        default: begin
                            resp_next = STAT_DONE;
                        end
                    endcase
                end
            end

            // fetch the current tail record
            ST_INS_RD: begin
                rd_addr    = idx_m1[AW-1:0];
                state_next = ST_INS_CMP;
            end

            // compare entry idx-1 with the new record, shift it up if lower
            ST_INS_CMP: begin
                rd_addr = idx_m2[AW-1:0];
                wr_en   = 1'b1;
                if (rd_data_reg.prio >= new_reg.prio) begin
                    wr_data    = new_reg;
                    fill_next  = fill_reg + OneC;
                    resp_next  = STAT_DONE;
                    state_next = ST_RESP;
                end else begin
                    wr_data  = rd_data_reg;
                    idx_next = idx_m1;
                    if (idx_reg == OneC) begin
                        state_next = ST_INS_PUT;
                    end
                end
            end

            // place the new record at the head position
            ST_INS_PUT: begin
                wr_en      = 1'b1;
                wr_data    = new_reg;
                fill_next  = fill_reg + OneC;
                resp_next  = STAT_DONE;
                state_next = ST_RESP;
            end

            ST_POP_RD: begin
                rd_addr    = '0;
                state_next = ST_POP_HEAD;
            end

            ST_POP_HEAD: begin
                rd_addr    = OneC[AW-1:0];
                rec_next   = rd_data_reg;
                idx_next   = OneC;
                state_next = ST_POP_SH;
            end

            // move entry idx down by one
            ST_POP_SH: begin
                rd_addr = idx_p1[AW-1:0];
                if (idx_reg < fill_reg) begin
                    wr_en    = 1'b1;
                    wr_addr  = idx_m1[AW-1:0];
                    wr_data  = rd_data_reg;
                    idx_next = idx_p1;
                end else begin
                    fill_next  = fill_reg - OneC;
                    resp_next  = STAT_RECORD;
                    state_next = ST_RESP;
                end
            end

            ST_LST_RD: begin
                rd_addr    = idx_reg[AW-1:0];
                state_next = ST_LST;
            end

            // scan, holding the latest match back until the next one shows
            ST_LST: begin
                rd_addr = idx_reg[AW-1:0];
                if (idx_reg < fill_reg) begin
                    if (go) begin
                        rd_addr  = idx_p1[AW-1:0];
                        idx_next = idx_p1;
                        if (hit) begin
                            rec_next  = rd_data_reg;
                            pend_next = 1'b1;
                            if (pend_reg) begin
                                out_load   = 1'b1;
                                out_status = STAT_RECORD;
                                out_rec    = rec_reg;
                                out_last   = 1'b0;
                            end
                        end
                    end
                end else begin
                    resp_next  = pend_reg ? STAT_RECORD : STAT_NONE;
                    state_next = ST_RESP;
                end
            end

            // final result of the command
            ST_RESP: begin
                if (slot_free) begin
                    out_load   = 1'b1;
                    out_status = resp_reg;
                    out_rec    = (resp_reg == STAT_RECORD) ? rec_reg : '0;
                    out_last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            pend_reg  <= pend_next;
        end
    end

    // command and working registers
    always_ff @(posedge aclk) begin
        idx_reg  <= idx_next;
        kind_reg <= kind_next;
        new_reg  <= new_next;
        rec_reg  <= rec_next;
        resp_reg <= resp_next;
    end

    // record memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entries_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= entries_reg[rd_addr];
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= out_status;
            m_rec_reg    <= out_rec;
            m_last_reg   <= out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{(TdataWidth - RecWidth){1'b0}}, m_rec_reg};

endmodule

`default_nettype wire
